/* rtl/keq_pkg.sv */
// Shared types, constants and pointer helpers for the keypad event queue.
`default_nettype none

package keq_pkg;

	// Queue geometry
	localparam int QUEUE_DEPTH = 4;
	localparam int PTR_MOD     = 2 * QUEUE_DEPTH;
	localparam int PTR_W       = $clog2(PTR_MOD);
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);

	// Field widths
	localparam int KEY_W   = 8;
	localparam int ACT_W   = 3;
	localparam int PAIR_W  = 2;
	localparam int FREE_W  = 3;
	localparam int CFG_IDX_W = 1;

	typedef logic [PTR_W-1:0]        ptr_t;
	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic signed [KEY_W-1:0] key_t;

	// Key code returned by pop or peek on an empty queue
	localparam key_t KEY_NONE = -8'sd1;

	// Pair counts reported by read pair
	localparam logic [PAIR_W-1:0] PAIR_NONE = 2'd0;
	localparam logic [PAIR_W-1:0] PAIR_ONE  = 2'd1;
	localparam logic [PAIR_W-1:0] PAIR_TWO  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_UP_KEY   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOWN_KEY = 1'd1;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH       = 3'd0,
		ACT_POP        = 3'd1,
		ACT_POP_NEWEST = 3'd2,
		ACT_PEEK       = 3'd3,
		ACT_READ_PAIR  = 3'd4,
		ACT_FLUSH      = 3'd5,
		ACT_LAST_KEY   = 3'd6,
		ACT_RESERVED   = 3'd7   // no effect, first key 0
	} action_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;  // latch the item and read the store
		logic commit;   // update pointers/store and load the result
	} cmd_t;

	// Pointer plus one, wrapping at twice the depth
	function automatic ptr_t ptr_inc(input ptr_t p);
		ptr_t r;
		if (int'(p) == PTR_MOD - 1) begin
			r = '0;
		end else begin
			r = p + ptr_t'(1);
		end
		return r;
	endfunction

	// Pointer minus n, wrapping at twice the depth
	function automatic ptr_t ptr_back(input ptr_t p, input ptr_t n);
		ptr_t r;
		if (p >= n) begin
			r = p - n;
		end else begin
			r = PTR_W'(int'(p) + PTR_MOD - int'(n));
		end
		return r;
	endfunction

	// Number of stored keys
	function automatic ptr_t fill_count(input ptr_t rp, input ptr_t wp);
		return ptr_back(wp, rp);
	endfunction

	// Store slot addressed by a pointer
	function automatic idx_t slot_idx(input ptr_t p);
		idx_t r;
		if (int'(p) >= QUEUE_DEPTH) begin
			r = IDX_W'(p - PTR_W'(QUEUE_DEPTH));
		end else begin
			r = IDX_W'(p);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/keq_ctrl.sv */
// Controller state machine: sequences capture and commit, owns the result valid.
`default_nettype none

module keq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	output keq_pkg::cmd_t      cmd
);

	keq_pkg::state_t state_q;
	keq_pkg::state_t state_n;
	logic            out_valid_q;
	logic            out_free;

	// Output register can take a new beat
	assign out_free = !out_valid_q || !out_stall;

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			keq_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_n = keq_pkg::ST_EXEC;
				end
			end
			keq_pkg::ST_EXEC: begin
				if (out_free) begin
					state_n = keq_pkg::ST_IDLE;
				end
			end
			default: state_n = keq_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_stall    = 1'b1;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			keq_pkg::ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			keq_pkg::ST_EXEC: begin
				cmd.commit = out_free;
			end
			default: in_stall = 1'b1;
		endcase
	end

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= keq_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* rtl/keq_datapath.sv */
// Datapath: key store, pointers, config registers and the result register.
`default_nettype none

module keq_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire keq_pkg::cmd_t                   cmd,
	input  wire logic                            cfg_we,
	input  wire logic [keq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [keq_pkg::KEY_W-1:0]       cfg_data,
	input  wire logic [keq_pkg::ACT_W-1:0]       action,
	input  wire logic signed [keq_pkg::KEY_W-1:0] key_value,
	input  wire logic                            shift_held,
	input  wire logic                            alt_held,
	output logic signed [keq_pkg::KEY_W-1:0]     first_key,
	output logic signed [keq_pkg::KEY_W-1:0]     second_key,
	output logic [keq_pkg::PAIR_W-1:0]           pair_count,
	output logic                                 has_room,
	output logic                                 queue_empty,
	output logic [keq_pkg::FREE_W-1:0]           free_slots
);

	// Config registers
	keq_pkg::key_t up_key_q;
	keq_pkg::key_t down_key_q;

	// Store and its per-slot written flags
	keq_pkg::key_t                   key_mem_q [keq_pkg::QUEUE_DEPTH];
	logic [keq_pkg::QUEUE_DEPTH-1:0] slot_vld_q;

	keq_pkg::ptr_t rd_ptr_q;
	keq_pkg::ptr_t wr_ptr_q;

	// Captured item and store reads
	logic [keq_pkg::ACT_W-1:0] action_s1;
	keq_pkg::key_t             key_s1;
	logic                      shift_s1;
	logic                      alt_s1;
	keq_pkg::key_t             rd_a_s1;
	keq_pkg::key_t             rd_b_s1;

	keq_pkg::idx_t addr_a;
	keq_pkg::idx_t addr_b;
	keq_pkg::idx_t addr_w;

	keq_pkg::ptr_t cnt;
	logic          empty;
	keq_pkg::ptr_t rd_ptr_n;
	keq_pkg::ptr_t wr_ptr_n;
	keq_pkg::ptr_t cnt_n;
	logic          do_write;
	keq_pkg::key_t first_n;
	keq_pkg::key_t second_n;
	logic [keq_pkg::PAIR_W-1:0] pair_n;

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_key_q   <= '0;
			down_key_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				keq_pkg::CFG_UP_KEY:   up_key_q   <= cfg_data;
				keq_pkg::CFG_DOWN_KEY: down_key_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Read addresses: port A serves oldest, second newest or else the newest, port B the newest
	always_comb begin
		addr_b = keq_pkg::slot_idx(keq_pkg::ptr_back(wr_ptr_q, keq_pkg::ptr_t'(1)));
		unique case (keq_pkg::action_t'(action))
			keq_pkg::ACT_POP,
			keq_pkg::ACT_PEEK:      addr_a = keq_pkg::slot_idx(rd_ptr_q);
			keq_pkg::ACT_READ_PAIR: addr_a = keq_pkg::slot_idx(
				keq_pkg::ptr_back(wr_ptr_q, keq_pkg::ptr_t'(2)));
			default:                addr_a = addr_b;
		endcase
	end

	// Capture stage: item fields and registered store reads
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_s1 <= action;
			key_s1    <= key_value;
			shift_s1  <= shift_held;
			alt_s1    <= alt_held;
			rd_a_s1   <= slot_vld_q[addr_a] ? key_mem_q[addr_a] : '0;
			rd_b_s1   <= slot_vld_q[addr_b] ? key_mem_q[addr_b] : '0;
		end
	end

	// Action decode
	always_comb begin
		cnt      = keq_pkg::fill_count(rd_ptr_q, wr_ptr_q);
		empty    = (rd_ptr_q == wr_ptr_q);
		rd_ptr_n = rd_ptr_q;
		wr_ptr_n = wr_ptr_q;
		do_write = 1'b0;
		first_n  = '0;
		second_n = '0;
		pair_n   = keq_pkg::PAIR_NONE;
		unique case (keq_pkg::action_t'(action_s1))
			keq_pkg::ACT_PUSH: begin
				if (int'(cnt) < keq_pkg::QUEUE_DEPTH) begin
					do_write = 1'b1;
					wr_ptr_n = keq_pkg::ptr_inc(wr_ptr_q);
				end
			end
			keq_pkg::ACT_POP: begin
				if (empty) begin
					first_n = keq_pkg::KEY_NONE;
				end else begin
					first_n  = rd_a_s1;
					rd_ptr_n = keq_pkg::ptr_inc(rd_ptr_q);
				end
			end
			keq_pkg::ACT_POP_NEWEST: begin
				// newest slot is taken, everything older is dropped
				if (empty) begin
					first_n = keq_pkg::KEY_NONE;
				end else begin
					first_n  = rd_a_s1;
					rd_ptr_n = wr_ptr_q;
				end
			end
			keq_pkg::ACT_PEEK: begin
				first_n = empty ? keq_pkg::KEY_NONE : rd_a_s1;
			end
			keq_pkg::ACT_READ_PAIR: begin
				if ((shift_s1 || alt_s1) && rd_b_s1 != '0) begin
					first_n  = rd_b_s1;
					second_n = shift_s1 ? up_key_q : down_key_q;
					pair_n   = keq_pkg::PAIR_TWO;
				end else if (int'(cnt) > 1) begin
					first_n  = rd_a_s1;
					second_n = rd_b_s1;
					pair_n   = keq_pkg::PAIR_TWO;
				end else if (int'(cnt) > 0) begin
					first_n = rd_b_s1;
					pair_n  = keq_pkg::PAIR_ONE;
				end
			end
			keq_pkg::ACT_FLUSH: begin
				rd_ptr_n = '0;
				wr_ptr_n = '0;
			end
			keq_pkg::ACT_LAST_KEY: begin
				first_n = rd_b_s1;
			end
			default: ;
		endcase
		cnt_n  = keq_pkg::fill_count(rd_ptr_n, wr_ptr_n);
		addr_w = keq_pkg::slot_idx(wr_ptr_q);
	end

	// Store write
	always_ff @(posedge clk) begin
		if (cmd.commit && do_write) begin
			key_mem_q[addr_w] <= key_s1;
		end
	end

	// Pointers and slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			slot_vld_q <= '0;
		end else if (cmd.commit) begin
			rd_ptr_q <= rd_ptr_n;
			wr_ptr_q <= wr_ptr_n;
			if (do_write) begin
				slot_vld_q[addr_w] <= 1'b1;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			first_key   <= first_n;
			second_key  <= second_n;
			pair_count  <= pair_n;
			has_room    <= (int'(cnt_n) < keq_pkg::QUEUE_DEPTH);
			queue_empty <= (rd_ptr_n == wr_ptr_n);
			if (int'(cnt_n) < keq_pkg::QUEUE_DEPTH) begin
				free_slots <= keq_pkg::FREE_W'(keq_pkg::ptr_t'(keq_pkg::QUEUE_DEPTH) - cnt_n);
			end else begin
				free_slots <= '0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/keypad_event_queue.sv */
// Keypad event queue top level: controller plus datapath.
// Flow: an item is captured with its registered store read, then committed with
// the pointer and store update and the result load; the commit waits while the
// previous result is still stalled on the output. A new item is not accepted
// until the previous one has been committed.
// Reset: arst_n clears pointers, slot flags, config registers and state.
`default_nettype none

module keypad_event_queue (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [keq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [keq_pkg::KEY_W-1:0]        cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [keq_pkg::ACT_W-1:0]        action,
	input  wire logic signed [keq_pkg::KEY_W-1:0] key_value,
	input  wire logic                             shift_held,
	input  wire logic                             alt_held,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic signed [keq_pkg::KEY_W-1:0]      first_key,
	output logic signed [keq_pkg::KEY_W-1:0]      second_key,
	output logic [keq_pkg::PAIR_W-1:0]            pair_count,
	output logic                                  has_room,
	output logic                                  queue_empty,
	output logic [keq_pkg::FREE_W-1:0]            free_slots
);

	keq_pkg::cmd_t cmd;

	keq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	keq_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.action      (action),
		.key_value   (key_value),
		.shift_held  (shift_held),
		.alt_held    (alt_held),
		.first_key   (first_key),
		.second_key  (second_key),
		.pair_count  (pair_count),
		.has_room    (has_room),
		.queue_empty (queue_empty),
		.free_slots  (free_slots)
	);

endmodule

`default_nettype wire

/* rtl/keq_checker.sv */
// Port-level assertions for the keypad event queue, bound to the top level.
`default_nettype none

module keq_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic                        has_room,
	input wire logic                        queue_empty,
	input wire logic [keq_pkg::FREE_W-1:0]  free_slots
);

	// A stalled result beat stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// One item in flight: an accepted beat is followed by a stall
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item accepted while one is in work");

	// A new result only appears out of the work cycle
	a_rose_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a work cycle");

	// Room flag agrees with the free slot count
	a_room_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (has_room == (free_slots != '0)))
		else $error("has_room disagrees with free_slots");

	// An empty queue has every slot free
	a_empty_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && queue_empty |->
			free_slots == keq_pkg::FREE_W'(keq_pkg::QUEUE_DEPTH))
		else $error("empty queue reports occupied slots");

endmodule

bind keypad_event_queue keq_checker u_keq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.has_room    (has_room),
	.queue_empty (queue_empty),
	.free_slots  (free_slots)
);

`default_nettype wire
